### rtl/clu_pkg.sv
// shared types and constants for the clamped logit unit
package clu_pkg;

    // mantissa width of the normalized log operand, Q1.31
    localparam int MANT_W = 32;
    // fraction bits of the log2 result and number of squaring cells
    localparam int FRAC_STEPS = 30;
    // log2 word: 5 integer bits over 30 fraction bits
    localparam int LOG_W = 35;
    // width of the padded compare path in the clamp stage
    localparam int CMP_W = 26;
    // ln(2) in Q0.28
    localparam logic [27:0] LN2_Q28 = 28'd186065280;

    // apb byte addresses of the two registers
    localparam logic [2:0] ADDR_CLAMP_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_EPS_VALUE    = 3'd4;

    typedef enum logic [1:0] {
        ST_FINITE  = 2'd0,
        ST_NEG_INF = 2'd1,
        ST_POS_INF = 2'd2
    } status_t;

    // payload handed from cell to cell
    typedef struct packed {
        logic [MANT_W-1:0] m_a;
        logic [MANT_W-1:0] m_b;
        logic [LOG_W-1:0]  la;
        logic [LOG_W-1:0]  lb;
        status_t           status;
    } cell_data_t;

endpackage

### rtl/clu_front.sv
// clamp, special value detect and log operand normalization
module clu_front
    import clu_pkg::*;
#(
    parameter int IN_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clamp_enable,
    input  logic [15:0]           eps_value,
    input  logic                  valid_in,
    input  logic [IN_FRAC_BITS:0] prob_in,
    output logic                  ready_out,
    output logic                  valid_out,
    output cell_data_t            data_out,
    input  logic                  ready_in
);

    localparam logic [CMP_W-1:0] ONE_IN = CMP_W'(1) << IN_FRAC_BITS;

    logic                  a_vld_reg;
    logic [IN_FRAC_BITS:0] x_reg;
    status_t               sta_reg;
    logic [IN_FRAC_BITS:0] x_next;
    status_t               sta_next;
    logic                  b_vld_reg;
    cell_data_t            data_reg;
    cell_data_t            data_next;
    logic                  a_ready;
    logic                  b_ready;

    // position of the leading one, zero for a zero operand
    function automatic logic [4:0] lead_one(input logic [IN_FRAC_BITS:0] v);
        logic [4:0] e;
        e = 5'd0;
        for (int i = 0; i <= IN_FRAC_BITS; i++) begin
            if (v[i])
            begin
                e = 5'(i);
            end
        end
        return e;
    endfunction

    // input saturation and eps clamp
    always_comb
    begin
        logic [CMP_W-1:0] xs;
        logic [CMP_W-1:0] eps_w;
        logic [CMP_W-1:0] hi;
        xs    = CMP_W'(prob_in);
        eps_w = CMP_W'(eps_value);
        if (xs > ONE_IN)
        begin
            xs = ONE_IN;
        end
        hi = (eps_w > ONE_IN) ? '0 : (ONE_IN - eps_w);
        if (clamp_enable)
        begin
            if (xs < eps_w)
            begin
                xs = eps_w;
            end
            else if (xs > hi)
            begin
                xs = hi;
            end
        end
        x_next = xs[IN_FRAC_BITS:0];
        if (xs == '0)
        begin
            sta_next = ST_NEG_INF;
        end
        else if (xs >= ONE_IN)
        begin
            sta_next = ST_POS_INF;
        end
        else
        begin
            sta_next = ST_FINITE;
        end
    end

    // normalize x and 1-x to Q1.31 mantissas with integer log parts
    always_comb
    begin
        logic [IN_FRAC_BITS:0] va;
        logic [IN_FRAC_BITS:0] vb;
        logic [4:0]            ea;
        logic [4:0]            eb;
        va = x_reg;
        vb = ONE_IN[IN_FRAC_BITS:0] - x_reg;
        ea = lead_one(va);
        eb = lead_one(vb);
        data_next.m_a    = MANT_W'(va) << (5'd31 - ea);
        data_next.m_b    = MANT_W'(vb) << (5'd31 - eb);
        data_next.la     = LOG_W'(ea) << FRAC_STEPS;
        data_next.lb     = LOG_W'(eb) << FRAC_STEPS;
        data_next.status = sta_reg;
    end

    assign b_ready   = !b_vld_reg || ready_in;
    assign a_ready   = !a_vld_reg || b_ready;
    assign ready_out = a_ready;
    assign valid_out = b_vld_reg;
    assign data_out  = data_reg;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_vld_reg <= valid_in;
            end
            if (b_ready)
            begin
                b_vld_reg <= a_vld_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (a_ready && valid_in)
        begin
            x_reg   <= x_next;
            sta_reg <= sta_next;
        end
        if (b_ready && a_vld_reg)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/clu_cell.sv
// one squaring cell: yields one fraction bit of log2 for both operands
module clu_cell
    import clu_pkg::*;
#(
    parameter int BIT_POS = 29
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid_in,
    input  cell_data_t data_in,
    output logic       ready_out,
    output logic       valid_out,
    output cell_data_t data_out,
    input  logic       ready_in
);

    logic       vld_reg;
    cell_data_t data_reg;
    cell_data_t data_next;

    // square each mantissa, renormalize and record the overflow bit
    always_comb
    begin
        logic [2*MANT_W-1:0] sq_a;
        logic [2*MANT_W-1:0] sq_b;
        logic [MANT_W:0]     t_a;
        logic [MANT_W:0]     t_b;
        sq_a      = {{MANT_W{1'b0}}, data_in.m_a} * {{MANT_W{1'b0}}, data_in.m_a};
        sq_b      = {{MANT_W{1'b0}}, data_in.m_b} * {{MANT_W{1'b0}}, data_in.m_b};
        t_a       = sq_a[2*MANT_W-1:MANT_W-1];
        t_b       = sq_b[2*MANT_W-1:MANT_W-1];
        data_next = data_in;
        if (t_a[MANT_W])
        begin
            data_next.m_a         = t_a[MANT_W:1];
            data_next.la[BIT_POS] = 1'b1;
        end
        else
        begin
            data_next.m_a = t_a[MANT_W-1:0];
        end
        if (t_b[MANT_W])
        begin
            data_next.m_b         = t_b[MANT_W:1];
            data_next.lb[BIT_POS] = 1'b1;
        end
        else
        begin
            data_next.m_b = t_b[MANT_W-1:0];
        end
    end

    assign ready_out = !vld_reg || ready_in;
    assign valid_out = vld_reg;
    assign data_out  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            vld_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### rtl/clu_back.sv
// log difference, scaling by ln2, rounding, saturation and output register
module clu_back
    import clu_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  cell_data_t  data_in,
    output logic        ready_out,
    output logic        out_valid,
    output logic [15:0] logit_value,
    output logic [1:0]  status,
    input  logic        out_stall
);

    localparam int SH     = 58 - OUT_FRAC_BITS;
    localparam int RW     = 64 - SH;
    localparam int LO_W   = 18;
    localparam int HI_W   = LOG_W - LO_W;
    localparam logic [63:0] HALF = 64'd1 << (SH - 1);

    logic                 d_vld_reg;
    logic                 d_neg_reg;
    logic [LOG_W-1:0]     d_mag_reg;
    status_t              d_sta_reg;
    logic                 m_vld_reg;
    logic                 m_neg_reg;
    logic [LO_W+27:0]     m_plo_reg;
    logic [HI_W+27:0]     m_phi_reg;
    status_t              m_sta_reg;
    logic                 r_vld_reg;
    logic                 r_neg_reg;
    logic [RW-1:0]        r_val_reg;
    status_t              r_sta_reg;
    logic                 o_vld_reg;
    logic [15:0]          o_val_reg;
    status_t              o_sta_reg;
    logic [15:0]          o_val_next;
    logic [63:0]          sum;
    logic                 d_ready;
    logic                 m_ready;
    logic                 r_ready;
    logic                 o_ready;

    assign o_ready   = !o_vld_reg || !out_stall;
    assign r_ready   = !r_vld_reg || o_ready;
    assign m_ready   = !m_vld_reg || r_ready;
    assign d_ready   = !d_vld_reg || m_ready;
    assign ready_out = d_ready;

    // rounded magnitude, half away from zero
    assign sum = (64'(m_phi_reg) << LO_W) + 64'(m_plo_reg) + HALF;

    // saturation and special values
    always_comb
    begin
        logic [31:0] r32;
        r32 = 32'(r_val_reg);
        case (r_sta_reg)
            ST_NEG_INF: o_val_next = 16'h8000;
            ST_POS_INF: o_val_next = 16'h7FFF;
            default:
            begin
                if (r_neg_reg)
                begin
                    o_val_next = (r32 > 32'd32768) ? 16'h8000 : (16'd0 - r32[15:0]);
                end
                else
                begin
                    o_val_next = (r32 > 32'd32767) ? 16'h7FFF : r32[15:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_vld_reg <= valid_in;
            end
            if (m_ready)
            begin
                m_vld_reg <= d_vld_reg;
            end
            if (r_ready)
            begin
                r_vld_reg <= m_vld_reg;
            end
            if (o_ready)
            begin
                o_vld_reg <= r_vld_reg;
            end
        end
    end

    // difference, split products, round and shift, output
    always_ff @(posedge clk)
    begin
        if (d_ready && valid_in)
        begin
            d_neg_reg <= data_in.la < data_in.lb;
            d_mag_reg <= (data_in.la < data_in.lb) ? (data_in.lb - data_in.la)
                                                   : (data_in.la - data_in.lb);
            d_sta_reg <= data_in.status;
        end
        if (m_ready && d_vld_reg)
        begin
            m_neg_reg <= d_neg_reg;
            m_plo_reg <= (LO_W+28)'(d_mag_reg[LO_W-1:0]) * (LO_W+28)'(LN2_Q28);
            m_phi_reg <= (HI_W+28)'(d_mag_reg[LOG_W-1:LO_W]) * (HI_W+28)'(LN2_Q28);
            m_sta_reg <= d_sta_reg;
        end
        if (r_ready && m_vld_reg)
        begin
            r_neg_reg <= m_neg_reg;
            r_val_reg <= sum[63:SH];
            r_sta_reg <= m_sta_reg;
        end
        if (o_ready && r_vld_reg)
        begin
            o_val_reg <= o_val_next;
            o_sta_reg <= r_sta_reg;
        end
    end

    assign out_valid   = o_vld_reg;
    assign logit_value = o_val_reg;
    assign status      = o_sta_reg;

endmodule

### rtl/clamped_logit_unit.sv
// clamped logit unit: one probability item in, one logit item out per cycle while out_stall is low
// stages: clamp/normalize, 30 squaring cells, scale/round/output
// throughput: one item per cycle while the output is not stalled; each squaring cell holds one item per cycle
// a full stall at the output fills all 36 stages before the input stalls
// reset: asynchronous, active low; clears stage valids, clamp_enable and eps_value
module clamped_logit_unit
    import clu_pkg::*;
#(
    parameter int IN_FRAC_BITS  = 16,
    parameter int OUT_FRAC_BITS = 11
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IN_FRAC_BITS:0] prob_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           logit_value,
    output logic [1:0]            status
);

    logic        clamp_enable_reg;
    logic [15:0] eps_value_reg;
    logic        front_ready;
    logic        back_ready;

    logic       vld_chain [0:FRAC_STEPS];
    logic       rdy_chain [0:FRAC_STEPS];
    cell_data_t dat_chain [0:FRAC_STEPS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_enable_reg <= 1'b0;
            eps_value_reg    <= 16'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_CLAMP_ENABLE)
            begin
                clamp_enable_reg <= pwdata[0];
            end
            else if (paddr == ADDR_EPS_VALUE)
            begin
                eps_value_reg <= pwdata[15:0];
            end
        end
    end

    // register readback
    always_comb
    begin
        case (paddr)
            ADDR_CLAMP_ENABLE: prdata = {31'd0, clamp_enable_reg};
            ADDR_EPS_VALUE:    prdata = {16'd0, eps_value_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign in_stall = !front_ready;

    clu_front #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .clamp_enable (clamp_enable_reg),
        .eps_value    (eps_value_reg),
        .valid_in     (in_valid),
        .prob_in      (prob_in),
        .ready_out    (front_ready),
        .valid_out    (vld_chain[0]),
        .data_out     (dat_chain[0]),
        .ready_in     (rdy_chain[0])
    );

    // chain of squaring cells, most significant fraction bit first
    for (genvar i = 0; i < FRAC_STEPS; i++)
    begin : g_cell
        clu_cell #(
            .BIT_POS(FRAC_STEPS - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (vld_chain[i]),
            .data_in   (dat_chain[i]),
            .ready_out (rdy_chain[i]),
            .valid_out (vld_chain[i+1]),
            .data_out  (dat_chain[i+1]),
            .ready_in  (rdy_chain[i+1])
        );
    end

    assign rdy_chain[FRAC_STEPS] = back_ready;

    clu_back #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (vld_chain[FRAC_STEPS]),
        .data_in     (dat_chain[FRAC_STEPS]),
        .ready_out   (back_ready),
        .out_valid   (out_valid),
        .logit_value (logit_value),
        .status      (status),
        .out_stall   (out_stall)
    );

    // minus infinity always carries the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_NEG_INF) |-> (logit_value == 16'h8000))
        else $error("minus infinity item without saturated value");

    // plus infinity always carries the most positive code
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_POS_INF) |-> (logit_value == 16'h7FFF))
        else $error("plus infinity item without saturated value");

    // an unstalled output lets the whole chain move
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    // a held output item stays put while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(logit_value) && $stable(status)))
        else $error("stalled output item changed");

endmodule
